@@ sv/medrm_pkg.sv @@
package medrm_pkg;

    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int MAX_WIDTH_DEF  = 4096;

    localparam int PIX_W       = 8;
    localparam int RES_W       = 9;
    localparam int MAP_W       = 9;
    localparam int CUM_W       = 33;
    localparam int DIM_W       = 13;
    localparam int DIM_CMP_W   = 17;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int OUT_RAW_W   = RES_W + MAP_W + CUM_W;
    localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    typedef enum logic {
        REG_HEIGHT = 1'b0,
        REG_WIDTH  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic first;
        logic col0;
        logic row0;
    } t_pos_kind;

    // last valid index of a dimension: zero acts as one, above max acts as max
    function automatic logic [DIM_CMP_W-1:0] dim_last(input logic [DIM_W-1:0] v,
                                                      input int maxv);
        logic [DIM_CMP_W-1:0] ext;
        ext = {{(DIM_CMP_W-DIM_W){1'b0}}, v};
        if (v == '0) begin
            return '0;
        end else if (ext > DIM_CMP_W'(maxv)) begin
            return DIM_CMP_W'(maxv - 1);
        end else begin
            return ext - DIM_CMP_W'(1);
        end
    endfunction

    // median edge detector
    function automatic logic [PIX_W-1:0] med_predict(input logic [PIX_W-1:0] a,
                                                     input logic [PIX_W-1:0] b,
                                                     input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] lo;
        logic [PIX_W-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c >= hi) begin
            return lo;
        end else if (c <= lo) begin
            return hi;
        end else begin
            return PIX_W'(a + b - c);
        end
    endfunction

endpackage

@@ sv/medrm_ram.sv @@
module medrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/medrm_calc.sv @@
module medrm_calc (
    input  logic [medrm_pkg::PIX_W-1:0]        i_pixel,
    input  logic [medrm_pkg::PIX_W-1:0]        i_left,
    input  logic [medrm_pkg::PIX_W-1:0]        i_up,
    input  logic [medrm_pkg::PIX_W-1:0]        i_upleft,
    input  medrm_pkg::t_pos_kind               i_kind,
    output logic signed [medrm_pkg::RES_W-1:0] o_residual,
    output logic [medrm_pkg::MAP_W-1:0]        o_mapped
);
    import medrm_pkg::*;

    logic [PIX_W-1:0]        pred;
    logic signed [RES_W-1:0] err;

    always_comb begin
        if (i_kind.col0) begin
            pred = i_up;
        end else if (i_kind.row0) begin
            pred = i_left;
        end else begin
            pred = med_predict(i_left, i_up, i_upleft);
        end
    end

    assign err = $signed({1'b0, pred}) - $signed({1'b0, i_pixel});

    always_comb begin
        if (i_kind.first) begin
            o_residual = $signed({1'b0, i_pixel});
            o_mapped   = {1'b0, i_pixel};
        end else begin
            o_residual = err;
            // zigzag: 2e, or 2|e|-1 when negative
            o_mapped   = {err[RES_W-2:0], 1'b0} ^ {MAP_W{err[RES_W-1]}};
        end
    end

endmodule

@@ sv/med_residual_mapper_core.sv @@
// channel   | dir | beat contents
// ----------+-----+-----------------------------------------------------------
// s stream  | in  | tdata[7:0] pixel
// m stream  | out | tdata[8:0] residual, [17:9] mapped, [50:18] cumulative; tlast image end
// apb       | in  | 0x0 image_height, 0x4 image_width (13 bits each)
//
// One pixel per cycle unless back-pressured; beats pass the input then the output register.
// Column store read and written at accept, read data feeds the compute stage.
// Output register holds under backpressure; input stage stalls only when both fill.
// Synchronous active-low reset clears position, sum and valids; column store is not cleared.
module med_residual_mapper_core #(
    parameter int MAX_HEIGHT = medrm_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH  = medrm_pkg::MAX_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [medrm_pkg::PIX_W-1:0]        i_s_tdata,   // pixel
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [medrm_pkg::OUT_TDATA_W-1:0]  o_m_tdata,   // residual, mapped, cumulative, pad
    output logic                               o_m_tlast,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [medrm_pkg::APB_AW-1:0]       paddr,
    input  logic [medrm_pkg::APB_DW-1:0]       pwdata,
    output logic [medrm_pkg::APB_DW-1:0]       prdata,
    output logic                               pready
);
    import medrm_pkg::*;

    localparam int HW = $clog2(MAX_HEIGHT);
    localparam int WW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [DIM_W-1:0] r_height;
    logic [DIM_W-1:0] r_width;
    t_reg_idx         cfg_idx;
    logic             cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= DIM_W'(1);
            r_width  <= DIM_W'(1);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                REG_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                default:    r_height <= r_height;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_HEIGHT: prdata = {{(APB_DW-DIM_W){1'b0}}, r_height};
            REG_WIDTH:  prdata = {{(APB_DW-DIM_W){1'b0}}, r_width};
            default:    prdata = '0;
        endcase
    end

    // scan position
    logic [DIM_CMP_W-1:0] h_last_ext;
    logic [DIM_CMP_W-1:0] w_last_ext;
    logic [HW-1:0]        h_last;
    logic [WW-1:0]        w_last;
    logic [HW-1:0]        r_row;
    logic [WW-1:0]        r_col;
    logic [HW-1:0]        n_row;
    logic [WW-1:0]        n_col;
    logic                 last_row;
    logic                 img_end;
    logic                 s_acc;
    logic                 b_adv;

    assign h_last_ext = dim_last(r_height, MAX_HEIGHT);
    assign w_last_ext = dim_last(r_width, MAX_WIDTH);
    assign h_last     = h_last_ext[HW-1:0];
    assign w_last     = w_last_ext[WW-1:0];
    assign last_row   = r_row >= h_last;
    assign img_end    = last_row && (r_col >= w_last);

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (img_end) begin
            n_row = '0;
            n_col = '0;
        end else if (last_row) begin
            n_row = '0;
            n_col = r_col + WW'(1);
        end else begin
            n_row = r_row + HW'(1);
        end
    end

    logic r_o_valid;
    logic r_a_valid;

    assign b_adv      = !r_o_valid || i_m_tready;
    assign o_s_tready = !r_a_valid || b_adv;
    assign s_acc      = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (s_acc) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // input stage
    logic [PIX_W-1:0] r_a_pixel;
    t_pos_kind        r_a_kind;
    logic             r_a_end;
    logic [PIX_W-1:0] left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_a_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_a_pixel      <= i_s_tdata;
            r_a_kind.first <= (r_row == '0) && (r_col == '0);
            r_a_kind.col0  <= r_col == '0;
            r_a_kind.row0  <= r_row == '0;
            r_a_end        <= img_end;
        end
    end

    medrm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_HEIGHT)
    ) u_col_store (
        .i_clk   (i_clk),
        .i_we    (s_acc),
        .i_waddr (r_row),
        .i_wdata (i_s_tdata),
        .i_re    (s_acc),
        .i_raddr (r_row),
        .o_rdata (left)
    );

    // compute stage
    logic [PIX_W-1:0]        r_up;
    logic [PIX_W-1:0]        r_upleft;
    logic signed [RES_W-1:0] residual;
    logic [MAP_W-1:0]        mapped;
    logic [CUM_W-1:0]        n_sum;
    logic [CUM_W-1:0]        r_sum;
    logic signed [RES_W-1:0] r_o_residual;
    logic [MAP_W-1:0]        r_o_mapped;
    logic                    r_o_end;

    medrm_calc u_calc (
        .i_pixel    (r_a_pixel),
        .i_left     (left),
        .i_up       (r_up),
        .i_upleft   (r_upleft),
        .i_kind     (r_a_kind),
        .o_residual (residual),
        .o_mapped   (mapped)
    );

    assign n_sum = r_a_kind.first ? {{(CUM_W-MAP_W){1'b0}}, mapped}
                                  : r_sum + {{(CUM_W-MAP_W){1'b0}}, mapped};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_up      <= '0;
            r_upleft  <= '0;
            r_sum     <= '0;
        end else begin
            if (b_adv) begin
                r_o_valid <= r_a_valid;
            end
            if (b_adv && r_a_valid) begin
                r_up     <= r_a_pixel;
                r_upleft <= left;
                r_sum    <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv && r_a_valid) begin
            r_o_residual <= residual;
            r_o_mapped   <= mapped;
            r_o_end      <= r_a_end;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tlast  = r_o_end;
    assign o_m_tdata  = {{(OUT_TDATA_W-OUT_RAW_W){1'b0}}, r_sum, r_o_mapped, r_o_residual};

    // assertions
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !i_m_tready && r_a_valid) |-> !o_s_tready)
        else $error("input taken while both stages are full");

    a_end_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && img_end) |=> (r_row == '0 && r_col == '0))
        else $error("scan position not rewound after image end");

    a_first_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_adv && r_a_valid && r_a_kind.first) |=>
        (o_m_tvalid && r_sum == {{(CUM_W-MAP_W){1'b0}}, r_o_mapped}))
        else $error("cumulative sum not restarted on first pixel");

endmodule
